>>> sv/version_attr_read_plan_defines.svh
// Assertion macros for the version attribute read planner.
// VAP_ASSERT expects i_clk and i_rst_n, VAP_ASSERT_RST i_clk, in the scope where it is used.
`ifndef VERSION_ATTR_READ_PLAN_DEFINES_SVH
`define VERSION_ATTR_READ_PLAN_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property outside reset.
`define VAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define VAP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VAP_ASSERT(lbl, prop, msg)
`define VAP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> sv/vap_pkg.sv
// ----------------------------------------------------------------------------
// vap_pkg
// Shared constants, codes and controller/datapath types of the read planner.
// ----------------------------------------------------------------------------
package vap_pkg;

    localparam int MAX_ATTRS  = 16;
    localparam int RING_CELLS = 8;
    localparam int BITMAP_W   = 16;
    localparam int RING_W     = $clog2(RING_CELLS);
    localparam int SIZE_IDX_W = $clog2(MAX_ATTRS + 1);
    localparam int ATTR_W     = $clog2(MAX_ATTRS + 2);
    localparam int STEP_W     = $clog2(RING_CELLS);

    typedef enum logic [1:0] {
        ACT_LOAD_SIZE = 2'd0,
        ACT_LOAD_CELL = 2'd1,
        ACT_PLAN      = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_POS    = 2'd0,
        KIND_FETCH  = 2'd1,
        KIND_MERGED = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ATTR,
        ST_WALK,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic  in_ready;
        logic  init;
        logic  adv_attr;
        logic  walk_start;
        logic  walk_step;
        logic  emit;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        t_action in_action;
        logic    plan_ok;
        logic    k_done;
        logic    newest_mod;
        logic    walk_stop;
        logic    walk_hit;
        logic    out_free;
    } t_status;

    // Attribute k (from 1) is marked by bit k-1; higher attributes never are.
    function automatic logic modified(input logic [BITMAP_W-1:0] bmp,
                                      input logic [ATTR_W-1:0] k);
        logic res;
        res = 1'b0;
        for (int b = 0; b < BITMAP_W; b++) begin
            if (int'(k) == b + 1) begin
                res = bmp[b];
            end
        end
        return res;
    endfunction

endpackage

>>> sv/vap_if.sv
// ----------------------------------------------------------------------------
// vap_in_if / vap_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface vap_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [4:0]  slot;
    logic [15:0] size_bytes;
    logic        cell_valid;
    logic [63:0] cell_version;
    logic [15:0] cell_bitmap;
    logic [31:0] cell_start;
    logic [63:0] snapshot_time;
    logic [31:0] base_offset;

    modport source (output valid, action, slot, size_bytes, cell_valid, cell_version,
                    cell_bitmap, cell_start, snapshot_time, base_offset, input ready);
    modport sink (input valid, action, slot, size_bytes, cell_valid, cell_version,
                  cell_bitmap, cell_start, snapshot_time, base_offset, output ready);
endinterface

interface vap_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] remote_offset;
    logic [19:0] length;
    logic [19:0] struct_offset;
    logic        empty_read;
    logic        last;

    modport source (output valid, kind, remote_offset, length, struct_offset,
                    empty_read, last, input ready);
    modport sink (input valid, kind, remote_offset, length, struct_offset,
                  empty_read, last, output ready);
endinterface

>>> sv/version_attr_read_plan.sv
// ----------------------------------------------------------------------------
// version_attr_read_plan
// Plans the remote reads of a versioned record from a size table and a ring
// of version cells.
// ----------------------------------------------------------------------------
// Channel   Dir  Carries
// i_item    in   load size, load cell or plan item
// o_res     out  position, fetch or merged read record
// i_cfg_*   in   attribute count register write
//
// A plan steps through accept, init, the attributes and the merged read. An
// attribute that the newest cell modified gets a position record; else the
// ring is walked one cell a cycle from the cell after the newest to a hit,
// which waits on a full result register, or to the stop. A stalled result
// register holds the sequencer. Reset is synchronous, clears valid marks and
// control, sets the count register to 16; no clearing pass.
// ----------------------------------------------------------------------------
`include "version_attr_read_plan_defines.svh"

module version_attr_read_plan (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vap_in_if.sink     i_item,
    vap_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);
    import vap_pkg::*;

    t_cmd    cmd;
    t_status status;

    vap_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vap_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status)
    );

    `VAP_ASSERT(a_emit_free, cmd.emit |-> status.out_free, "result overwritten while pending")
    `VAP_ASSERT(a_idle_no_emit, i_item.ready |-> !cmd.emit, "result emitted while idle")
    `VAP_ASSERT(a_last_merged, o_res.valid && o_res.last |-> o_res.kind == KIND_MERGED, "bad last")
    `VAP_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_res.valid, "result valid after reset")

endmodule

>>> sv/vap_datapath.sv
// ----------------------------------------------------------------------------
// vap_datapath
// Size table, version ring, running sums, walk pointer and result register.
// ----------------------------------------------------------------------------
module vap_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vap_in_if.sink          i_item,
    vap_out_if.source       o_res,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_data,
    input  vap_pkg::t_cmd   i_cmd,
    output vap_pkg::t_status o_status
);
    import vap_pkg::*;

    logic [4:0]          r_attr_count;
    logic [15:0]         r_size [0:MAX_ATTRS];
    logic                r_valid [RING_CELLS];
    logic [63:0]         r_version [RING_CELLS];
    logic [BITMAP_W-1:0] r_bitmap [RING_CELLS];
    logic [31:0]         r_start [RING_CELLS];
    logic [31:0]         r_acc [RING_CELLS];

    logic [RING_W-1:0]   r_newest;
    logic [63:0]         r_snap;
    logic [31:0]         r_base;
    logic [BITMAP_W-1:0] r_nb;
    logic [31:0]         r_nstart;
    logic [15:0]         r_size0;
    logic [ATTR_W-1:0]   r_k;
    logic [31:0]         r_sum;
    logic [RING_W-1:0]   r_vc;
    logic [STEP_W-1:0]   r_steps;

    logic                r_ov;
    logic [1:0]          r_kind;
    logic [31:0]         r_roff;
    logic [19:0]         r_len;
    logic [19:0]         r_soff;
    logic                r_empty;
    logic                r_last;

    logic                accept;
    logic [ATTR_W-1:0]   n_eff;
    logic [15:0]         cur_size;
    logic [31:0]         total;
    logic                out_free;
    logic [RING_W-1:0]   newest_nxt;
    logic [RING_W-1:0]   vc_nxt;

    assign i_item.ready = i_cmd.in_ready;
    assign accept       = i_item.valid && i_cmd.in_ready;
    assign n_eff        = (int'(r_attr_count) > MAX_ATTRS) ? ATTR_W'(MAX_ATTRS)
                                                           : ATTR_W'(r_attr_count);
    assign cur_size     = r_size[SIZE_IDX_W'(r_k)];
    assign total        = r_acc[r_newest];
    assign out_free     = !r_ov || o_res.ready;
    assign newest_nxt   = (int'(r_newest) == RING_CELLS - 1) ? '0 : r_newest + 1'b1;
    assign vc_nxt       = (int'(r_vc) == RING_CELLS - 1) ? '0 : r_vc + 1'b1;

    // Report status to the controller
    always_comb begin
        o_status.in_valid   = i_item.valid;
        o_status.in_action  = t_action'(i_item.action);
        o_status.plan_ok    = int'(i_item.slot) < RING_CELLS;
        o_status.k_done     = r_k > n_eff;
        o_status.newest_mod = modified(r_nb, r_k);
        o_status.walk_stop  = (int'(r_steps) == RING_CELLS - 1) || !r_valid[r_vc]
                              || !(r_version[r_vc] > r_snap);
        o_status.walk_hit   = modified(r_bitmap[r_vc], r_k);
        o_status.out_free   = out_free;
    end

    // Hold the attribute count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_count <= 5'd16;
        end else if (i_cfg_we) begin
            r_attr_count <= i_cfg_data;
        end
    end

    // Load the size table and ring cells
    always_ff @(posedge i_clk) begin
        if (accept && t_action'(i_item.action) == ACT_LOAD_SIZE
            && int'(i_item.slot) <= MAX_ATTRS) begin
            r_size[SIZE_IDX_W'(i_item.slot)] <= i_item.size_bytes;
        end
        if (accept && t_action'(i_item.action) == ACT_LOAD_CELL
            && int'(i_item.slot) < RING_CELLS) begin
            r_version[RING_W'(i_item.slot)] <= i_item.cell_version;
            r_bitmap[RING_W'(i_item.slot)]  <= i_item.cell_bitmap;
            r_start[RING_W'(i_item.slot)]   <= i_item.cell_start;
        end
    end

    // Valid marks clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < RING_CELLS; c++) begin
                r_valid[c] <= 1'b0;
            end
        end else if (accept && t_action'(i_item.action) == ACT_LOAD_CELL
                     && int'(i_item.slot) < RING_CELLS) begin
            r_valid[RING_W'(i_item.slot)] <= i_item.cell_valid;
        end
    end

    // Latch plan fields, run prefix sums and walk pointer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_newest <= RING_W'(i_item.slot);
            r_snap   <= i_item.snapshot_time;
            r_base   <= i_item.base_offset;
        end
        if (i_cmd.init) begin
            r_nb     <= r_bitmap[r_newest];
            r_nstart <= r_start[r_newest];
            r_size0  <= r_size[0];
            r_k      <= ATTR_W'(1);
            r_sum    <= '0;
            for (int c = 0; c < RING_CELLS; c++) begin
                r_acc[c] <= '0;
            end
        end
        if (i_cmd.adv_attr) begin
            r_sum <= r_sum + 32'(cur_size);
            r_k   <= r_k + 1'b1;
            for (int c = 0; c < RING_CELLS; c++) begin
                if (modified(r_bitmap[c], r_k)) begin
                    r_acc[c] <= r_acc[c] + 32'(cur_size);
                end
            end
        end
        if (i_cmd.walk_start) begin
            r_vc    <= newest_nxt;
            r_steps <= '0;
        end
        if (i_cmd.walk_step) begin
            r_vc    <= vc_nxt;
            r_steps <= r_steps + 1'b1;
        end
    end

    // Result register: advance on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            unique case (i_cmd.kind)
                KIND_POS: begin
                    r_roff  <= '0;
                    r_len   <= 20'(cur_size);
                    r_soff  <= 20'(32'(r_size0) + r_sum);
                    r_empty <= 1'b0;
                    r_last  <= 1'b0;
                end
                KIND_FETCH: begin
                    r_roff  <= r_start[r_vc] + r_acc[r_vc] + r_base;
                    r_len   <= 20'(cur_size);
                    r_soff  <= r_sum[19:0];
                    r_empty <= 1'b0;
                    r_last  <= 1'b0;
                end
                default: begin
                    r_roff  <= r_nstart + r_base;
                    r_len   <= total[19:0];
                    r_soff  <= '0;
                    r_empty <= (total == 32'd0);
                    r_last  <= 1'b1;
                end
            endcase
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.kind          = r_kind;
    assign o_res.remote_offset = r_roff;
    assign o_res.length        = r_len;
    assign o_res.struct_offset = r_soff;
    assign o_res.empty_read    = r_empty;
    assign o_res.last          = r_last;

endmodule

>>> sv/vap_ctrl.sv
// ----------------------------------------------------------------------------
// vap_ctrl
// Sequencer over attributes and ring walks of one plan item.
// ----------------------------------------------------------------------------
module vap_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vap_pkg::t_status  i_status,
    output vap_pkg::t_cmd     o_cmd
);
    import vap_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid && i_status.in_action == ACT_PLAN
                    && i_status.plan_ok) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: n_state = ST_ATTR;
            ST_ATTR: begin
                priority if (i_status.k_done) begin
                    n_state = ST_FINAL;
                end else if (!i_status.newest_mod) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                priority if (i_status.walk_stop) begin
                    n_state = ST_ATTR;
                end else if (i_status.walk_hit && i_status.out_free) begin
                    n_state = ST_ATTR;
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.kind = KIND_POS;
        unique case (r_state)
            ST_IDLE: o_cmd.in_ready = 1'b1;
            ST_INIT: o_cmd.init = 1'b1;
            ST_ATTR: begin
                priority if (i_status.k_done) begin
                    o_cmd.emit = 1'b0;
                end else if (i_status.newest_mod) begin
                    if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.kind     = KIND_POS;
                        o_cmd.adv_attr = 1'b1;
                    end
                end else begin
                    o_cmd.walk_start = 1'b1;
                end
            end
            ST_WALK: begin
                priority if (i_status.walk_stop) begin
                    o_cmd.adv_attr = 1'b1;
                end else if (i_status.walk_hit) begin
                    if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.kind     = KIND_FETCH;
                        o_cmd.adv_attr = 1'b1;
                    end
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_MERGED;
                end
            end
            default: o_cmd.in_ready = 1'b0;
        endcase
    end

endmodule
